[rtl/core/lmsp_pkg.sv]
// types and constants shared by the led matrix scan pattern player
package lmsp_pkg;

   localparam int LED_COUNT      = 16;
   localparam int LED_COLS       = 4;
   localparam int WORDS_PER_STEP = 8;
   localparam int WAIT_WORD      = 8;
   localparam int LEVEL_W        = 8;
   localparam int SCALE_W        = 9;
   localparam int COMPARE_W      = 9;
   localparam int TIMEOUT_W      = 11;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 5;

   localparam logic [SCALE_W-1:0]   SCALE_UNITY  = 9'h100;
   localparam logic [COMPARE_W-1:0] COMPARE_OFF  = 9'h100;

   typedef enum logic [1:0] {
      FUNC_SCAN    = 2'd0,
      FUNC_FRAME   = 2'd1,
      FUNC_WRITE   = 2'd2,
      FUNC_RESTART = 2'd3
   } func_type;

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_PLAY = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_ADJUST    = 2'd2;

   typedef logic [WORDS_PER_STEP:0][31:0] row_type;

   typedef struct packed {
      func_type            func;
      logic [SCALE_W-1:0]  white_scale;
      logic [SCALE_W-1:0]  purple_scale;
      logic [3:0]          step_select;
      logic [3:0]          word_select;
      logic [31:0]         word_data;
   } req_type;

   typedef struct packed {
      logic [1:0]           active_row;
      logic [1:0]           active_col;
      logic [COMPARE_W-1:0] white_compare;
      logic [COMPARE_W-1:0] purple_compare;
   } rsp_type;

endpackage

[rtl/core/led_matrix_scan_pattern_player.sv]
// 4x4 two-color led matrix scanner with pattern player, top level
// Takes one request per clock cycle unless a scan request waits in the input
// register while an earlier response is held; the response to a scan tick comes
// through the input register and then the result register, and frame ticks,
// pattern writes and restarts give no response. The pattern store holds one row
// per step and is read one frame ahead, so a playback frame tick that ends a
// step's wait loads all 32 levels at once. The pattern store needs no clearing
// after reset; a step must be written before playback reaches it.
module led_matrix_scan_pattern_player #(
   parameter int PATTERN_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lmsp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lmsp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [lmsp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lmsp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lmsp_pkg::*;

   localparam int SW = (PATTERN_STEPS > 1) ? $clog2(PATTERN_STEPS) : 1;
   localparam int PW = $clog2(PATTERN_STEPS + 1);
   localparam int LW = ((PW > 5) ? PW : 5) + 1;

   // configuration
   logic [1:0]            display_mode_ff;
   logic [4:0]            pattern_length_ff;
   logic [4:0]            pattern_length_in;
   logic                  auto_adjust_ff;

   // pipeline
   logic                  in_valid_ff;
   req_type               in_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   logic                  advance;
   logic                  out_free;

   // player state
   logic [3:0]            lit_ff, lit_in;
   logic [LEVEL_W-1:0]    white_ff [LED_COUNT];
   logic [LEVEL_W-1:0]    white_in [LED_COUNT];
   logic [LEVEL_W-1:0]    purple_ff [LED_COUNT];
   logic [LEVEL_W-1:0]    purple_in [LED_COUNT];
   logic [PW-1:0]         play_step_ff, play_step_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;

   // pattern store with one-frame-ahead row fetch
   row_type               pat_mem [PATTERN_STEPS];
   row_type               rd_row_ff;
   row_type               row_eff;
   logic                  fwd_hit_ff;
   logic [3:0]            fwd_sel_ff;
   logic [31:0]           fwd_data_ff;
   logic                  mem_we;
   logic [SW-1:0]         wr_step;
   logic [SW-1:0]         rd_addr;
   logic [SW-1:0]         next_cur;
   logic [LW-1:0]         len;
   logic [LW-1:0]         rd_len;

   // result datapath
   logic [SCALE_W-1:0]    white_scale, purple_scale;
   logic [16:0]           white_prod, purple_prod;
   logic [LEVEL_W-1:0]    white_lv, purple_lv;
   logic [LEVEL_W-1:0]    wait_val;

   function automatic logic [SW-1:0] next_step(input logic [PW-1:0] ps,
                                               input logic [LW-1:0] ln);
      logic [LW-1:0] nx;
      nx = LW'(ps) + LW'(1);
      if (nx >= ln) begin
         nx = '0;
      end
      return SW'(nx);
   endfunction

   function automatic logic [LW-1:0] clamp_len(input logic [4:0] l);
      logic [LW-1:0] r;
      r = LW'(l);
      if (r == '0) begin
         r = LW'(1);
      end
      if (r > LW'(PATTERN_STEPS)) begin
         r = LW'(PATTERN_STEPS);
      end
      return r;
   endfunction

   function automatic logic [SCALE_W-1:0] eff_scale(input logic auto_on,
                                                   input logic [SCALE_W-1:0] s);
      logic [SCALE_W-1:0] r;
      r = SCALE_UNITY;
      if (auto_on && s < SCALE_UNITY) begin
         r = s;
      end
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && ((in_ff.func != FUNC_SCAN) || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // length seen by the row fetch follows a write in the same cycle
   assign pattern_length_in = (csr_we && (csr_index == CSR_PATTERN_LENGTH)) ? csr_wdata
                                                                           : pattern_length_ff;
   assign len    = clamp_len(pattern_length_ff);
   assign rd_len = clamp_len(pattern_length_in);

   assign next_cur = next_step(play_step_ff, len);

   always_comb begin
      row_eff = rd_row_ff;
      if (fwd_hit_ff) begin
         row_eff[fwd_sel_ff] = fwd_data_ff;
      end
   end

   assign wait_val = row_eff[WAIT_WORD][LEVEL_W-1:0];

   assign wr_step = SW'(in_ff.step_select);
   assign mem_we  = advance && (in_ff.func == FUNC_WRITE)
                    && ({3'b000, in_ff.step_select} < 7'(PATTERN_STEPS))
                    && (in_ff.word_select <= 4'(WAIT_WORD));

   // player state update
   always_comb begin
      lit_in       = lit_ff;
      play_step_in = play_step_ff;
      timeout_in   = timeout_ff;
      for (int i = 0; i < LED_COUNT; i++) begin
         white_in[i]  = white_ff[i];
         purple_in[i] = purple_ff[i];
      end
      if (advance) begin
         unique case (in_ff.func)
            FUNC_SCAN: begin
               lit_in = lit_ff + 4'd1;
            end
            FUNC_FRAME: begin
               if (display_mode_ff == MODE_OFF) begin
                  for (int i = 0; i < LED_COUNT; i++) begin
                     white_in[i]  = '0;
                     purple_in[i] = '0;
                  end
               end else if (display_mode_ff == MODE_PLAY) begin
                  if (timeout_ff != '0) begin
                     timeout_in = timeout_ff - TIMEOUT_W'(1);
                  end else begin
                     play_step_in = PW'(next_cur);
                     timeout_in   = {1'b0, wait_val, 2'b00} + TIMEOUT_W'(wait_val);
                     for (int i = 0; i < 4; i++) begin
                        for (int k = 0; k < 4; k++) begin
                           white_in[4*i+k]  = row_eff[i][8*k +: 8];
                           purple_in[4*i+k] = row_eff[4+i][8*k +: 8];
                        end
                     end
                  end
               end
            end
            FUNC_WRITE: begin
            end
            FUNC_RESTART: begin
               play_step_in = PW'(PATTERN_STEPS);
               timeout_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_addr = next_step(play_step_in, rd_len);

   // compare values for the newly lit led
   assign white_lv     = white_ff[lit_in];
   assign purple_lv    = purple_ff[lit_in];
   assign white_scale  = eff_scale(auto_adjust_ff, in_ff.white_scale);
   assign purple_scale = eff_scale(auto_adjust_ff, in_ff.purple_scale);
   assign white_prod   = 17'(white_lv) * 17'(white_scale);
   assign purple_prod  = 17'(purple_lv) * 17'(purple_scale);

   // pattern store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pat_mem[wr_step][in_ff.word_select] <= in_ff.word_data;
      end
      rd_row_ff   <= pat_mem[rd_addr];
      fwd_hit_ff  <= mem_we && (wr_step == rd_addr);
      fwd_sel_ff  <= in_ff.word_select;
      fwd_data_ff <= in_ff.word_data;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff   <= MODE_OFF;
         pattern_length_ff <= 5'd1;
         auto_adjust_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:   display_mode_ff   <= csr_wdata[1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata;
            CSR_AUTO_ADJUST:    auto_adjust_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input register, state and result register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance && (in_ff.func == FUNC_SCAN)) begin
         rsp_ff.active_row     <= lit_in[3:2];
         rsp_ff.active_col     <= lit_in[1:0];
         rsp_ff.white_compare  <= COMPARE_OFF - COMPARE_W'(white_prod[16:8]);
         rsp_ff.purple_compare <= COMPARE_OFF - COMPARE_W'(purple_prod[16:8]);
      end
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lit_ff       <= '0;
         play_step_ff <= PW'(PATTERN_STEPS);
         timeout_ff   <= '0;
         for (int i = 0; i < LED_COUNT; i++) begin
            white_ff[i]  <= '0;
            purple_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance && (in_ff.func == FUNC_SCAN)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         lit_ff       <= lit_in;
         play_step_ff <= play_step_in;
         timeout_ff   <= timeout_in;
         for (int i = 0; i < LED_COUNT; i++) begin
            white_ff[i]  <= white_in[i];
            purple_ff[i] <= purple_in[i];
         end
      end
   end

endmodule
